@@ design/sire_pkg.sv @@
`default_nettype none
package sire_pkg;

    localparam int unsigned RADIX_W   = 5;
    localparam int unsigned DIGIT_W   = 4;
    localparam int unsigned NUM_W     = 32;
    localparam int unsigned SYM_W     = 8;
    localparam int unsigned ALPHA_W   = 128;
    localparam int unsigned NUM_SYMS  = 16;
    localparam int unsigned MAX_DIGITS = 32;
    localparam logic [RADIX_W-1:0] MAX_RADIX = 5'd16;

    localparam logic [1:0] REG_RADIX      = 2'd0;
    localparam logic [1:0] REG_ALPHA_LOW  = 2'd1;
    localparam logic [1:0] REG_ALPHA_HIGH = 2'd2;

    localparam logic [SYM_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [SYM_W-1:0] CH_PERCENT = 8'h25;
    localparam logic [SYM_W-1:0] CH_EQUAL   = 8'h3D;
    localparam logic [SYM_W-1:0] CH_STAR    = 8'h2A;
    localparam logic [SYM_W-1:0] CH_SLASH   = 8'h2F;
    localparam logic [SYM_W-1:0] CH_BANG    = 8'h21;
    localparam logic [SYM_W-1:0] CH_TILDE   = 8'h7E;

    typedef struct packed {
        logic push;
        logic pop;
    } t_stk_ctl;

    typedef struct packed {
        logic                done;
        logic                q_zero;
        logic [DIGIT_W-1:0]  digit;
    } t_div_st;

    typedef struct packed {
        logic done;
        logic bad;
    } t_val_st;

    function automatic logic [SYM_W-1:0] sym_at(input logic [ALPHA_W-1:0] alpha,
                                                input logic [DIGIT_W-1:0] k);
        sym_at = alpha[k*SYM_W +: SYM_W];
    endfunction

    function automatic logic sym_bad(input logic [SYM_W-1:0] c);
        logic ok;
        ok = (c inside {[CH_BANG:CH_TILDE]}) &&
             !(c inside {CH_PERCENT, CH_EQUAL, [CH_STAR:CH_SLASH]});
        sym_bad = !ok;
    endfunction

endpackage
`default_nettype wire

@@ design/sire_valid.sv @@
`default_nettype none
module sire_valid
    import sire_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [RADIX_W-1:0]   i_radix,
    input  wire logic [ALPHA_W-1:0]   i_alpha,
    output t_val_st                   o_st
);

    logic               r_act;
    logic               r_done;
    logic               r_bad;
    logic [DIGIT_W-1:0] r_idx;

    logic [SYM_W-1:0]   cur;
    logic               dup;
    logic               is_last;

    // one symbol a cycle, compared against every symbol below it
    always_comb begin
        cur = sym_at(i_alpha, r_idx);
        dup = 1'b0;
        for (int j = 0; j < NUM_SYMS; j++) begin
            if (DIGIT_W'(j) < r_idx && sym_at(i_alpha, DIGIT_W'(j)) == cur) begin
                dup = 1'b1;
            end
        end
        is_last = ({1'b0, r_idx} == i_radix - RADIX_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= 1'b0;
            r_done <= 1'b0;
            r_bad  <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_idx <= '0;
                r_bad <= (i_radix < RADIX_W'(2));
                if (i_radix < RADIX_W'(2)) begin
                    r_done <= 1'b1;
                end else begin
                    r_act <= 1'b1;
                end
            end else if (r_act) begin
                r_bad <= r_bad | sym_bad(cur) | dup;
                r_idx <= r_idx + DIGIT_W'(1);
                if (is_last) begin
                    r_act  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_st = {r_done, r_bad};

endmodule
`default_nettype wire

@@ design/sire_div.sv @@
`default_nettype none
module sire_div
    import sire_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_load,
    input  wire logic [NUM_W-1:0]     i_value,
    input  wire logic                 i_run,
    input  wire logic [RADIX_W-1:0]   i_radix,
    output t_div_st                   o_st
);

    localparam logic [RADIX_W-1:0] LAST_BIT = RADIX_W'(NUM_W - 1);

    logic               r_act;
    logic               r_done;
    logic [RADIX_W-1:0] r_cnt;
    logic [NUM_W-1:0]   r_dvd;
    logic [DIGIT_W-1:0] r_rem;

    logic [RADIX_W-1:0] trial;
    logic [RADIX_W-1:0] diff;
    logic               ge;

    // restoring division, one dividend bit a cycle; quotient shifts back into r_dvd
    always_comb begin
        trial = {r_rem, r_dvd[NUM_W-1]};
        ge    = (trial >= i_radix);
        diff  = trial - i_radix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_act && (r_cnt == LAST_BIT);
            if (i_run) begin
                r_act <= 1'b1;
                r_cnt <= '0;
            end else if (r_act) begin
                r_cnt <= r_cnt + RADIX_W'(1);
                if (r_cnt == LAST_BIT) begin
                    r_act <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_dvd <= i_value;
        end else if (i_run) begin
            r_rem <= '0;
        end else if (r_act) begin
            r_dvd <= {r_dvd[NUM_W-2:0], ge};
            r_rem <= ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
        end
    end

    assign o_st = {r_done, (r_dvd == '0), r_rem};

endmodule
`default_nettype wire

@@ design/sire_stack.sv @@
`default_nettype none
module sire_stack
    import sire_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire t_stk_ctl             i_ctl,
    input  wire logic [DIGIT_W-1:0]   i_digit,
    output logic [DIGIT_W-1:0]        o_top
);

    // digits arrive least significant first, so the top is the most significant
    logic [DIGIT_W-1:0] r_stk [MAX_DIGITS];

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_stk[0] <= i_digit;
            for (int i = 1; i < MAX_DIGITS; i++) begin
                r_stk[i] <= r_stk[i-1];
            end
        end else if (i_ctl.pop) begin
            for (int i = 0; i < MAX_DIGITS - 1; i++) begin
                r_stk[i] <= r_stk[i+1];
            end
        end
    end

    assign o_top = r_stk[0];

endmodule
`default_nettype wire

@@ design/signed_integer_radix_digit_emitter.sv @@
`default_nettype none
// Converts a signed 32-bit number to its digits in a configured radix (2..16),
// most significant first, each digit shown as a byte of the configured alphabet;
// a negative number first gives '-', and the final symbol carries o_last. An
// invalid alphabet gives one result with o_base_invalid and o_last set and a zero
// symbol. Results come one per cycle with o_valid and cannot be held off, so the
// receiver must take every strobed cycle. A new start is accepted only while idle;
// the alphabet check visits one symbol a cycle, then each digit takes one pass of
// the bit-serial divider, one shift per dividend bit, and a handoff. A radix
// below two is flagged invalid without visiting the symbols. Write configuration
// only while o_busy is low.
module signed_integer_radix_digit_emitter
    import sire_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [1:0]           i_cfg_idx,
    input  wire logic [63:0]          i_cfg_data,
    input  wire logic                 i_start,
    input  wire logic signed [NUM_W-1:0] i_number,
    output logic                      o_busy,
    output logic                      o_valid,
    output logic [SYM_W-1:0]          o_symbol,
    output logic                      o_last,
    output logic                      o_base_invalid
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [RADIX_W-1:0] r_radix;
    logic [63:0]        r_alpha_lo;
    logic [63:0]        r_alpha_hi;

    logic [1:0]         r_state;
    logic               r_sign_pend;
    logic [RADIX_W:0]   r_nd;

    logic               r_valid;
    logic [SYM_W-1:0]   r_symbol;
    logic               r_last;
    logic               r_inv;

    logic [RADIX_W-1:0] eff_radix;
    logic [ALPHA_W-1:0] alpha;
    logic               accept;
    logic [NUM_W-1:0]   mag;
    logic               div_run;
    t_val_st            val_st;
    t_div_st            div_st;
    t_stk_ctl           stk_ctl;
    logic [DIGIT_W-1:0] top_digit;

    assign eff_radix = (r_radix > MAX_RADIX) ? MAX_RADIX : r_radix;
    assign alpha     = {r_alpha_hi, r_alpha_lo};
    assign accept    = i_start && (r_state == ST_IDLE);
    assign mag       = i_number[NUM_W-1] ? (NUM_W'(0) - NUM_W'(i_number)) : NUM_W'(i_number);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix    <= '0;
            r_alpha_lo <= '0;
            r_alpha_hi <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_RADIX:      r_radix    <= i_cfg_data[RADIX_W-1:0];
                REG_ALPHA_LOW:  r_alpha_lo <= i_cfg_data;
                REG_ALPHA_HIGH: r_alpha_hi <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        div_run      = 1'b0;
        stk_ctl.push = 1'b0;
        stk_ctl.pop  = 1'b0;
        case (r_state)
            ST_CHECK: div_run = val_st.done && !val_st.bad;
            ST_DIV: begin
                stk_ctl.push = div_st.done;
                div_run      = div_st.done && !div_st.q_zero;
            end
            ST_EMIT: stk_ctl.pop = !r_sign_pend;
            default: ;
        endcase
    end

    sire_valid u_valid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_radix (eff_radix),
        .i_alpha (alpha),
        .o_st    (val_st)
    );

    sire_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_value (mag),
        .i_run   (div_run),
        .i_radix (eff_radix),
        .o_st    (div_st)
    );

    sire_stack u_stack (
        .i_clk   (i_clk),
        .i_ctl   (stk_ctl),
        .i_digit (div_st.digit),
        .o_top   (top_digit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            r_nd    <= '0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_state <= ST_CHECK;
                        r_nd    <= '0;
                    end
                end
                ST_CHECK: begin
                    if (val_st.done) begin
                        if (val_st.bad) begin
                            r_valid <= 1'b1;
                            r_state <= ST_IDLE;
                        end else begin
                            r_state <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_st.done) begin
                        r_nd <= r_nd + (RADIX_W+1)'(1);
                        if (div_st.q_zero) begin
                            r_state <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT: begin
                    r_valid <= 1'b1;
                    if (!r_sign_pend) begin
                        r_nd <= r_nd - (RADIX_W+1)'(1);
                        if (r_nd == (RADIX_W+1)'(1)) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sign_pend <= i_number[NUM_W-1];
        end
        case (r_state)
            ST_CHECK: begin
                r_symbol <= '0;
                r_last   <= 1'b1;
                r_inv    <= 1'b1;
            end
            ST_EMIT: begin
                r_inv <= 1'b0;
                if (r_sign_pend) begin
                    r_symbol    <= CH_MINUS;
                    r_last      <= 1'b0;
                    r_sign_pend <= 1'b0;
                end else begin
                    r_symbol <= sym_at(alpha, top_digit);
                    r_last   <= (r_nd == (RADIX_W+1)'(1));
                end
            end
            default: ;
        endcase
    end

    assign o_busy         = (r_state != ST_IDLE);
    assign o_valid        = r_valid;
    assign o_symbol       = r_symbol;
    assign o_last         = r_last;
    assign o_base_invalid = r_inv;

endmodule
`default_nettype wire
